// ===== design/irt_pkg.sv =====
// ----------------------------------------------------------------------------
// irt_pkg: shared types for the interval reservation table
// payload structs, opcode and status codes, controller state and the
// command and status groups between controller and datapath
// ----------------------------------------------------------------------------
package irt_pkg;

    localparam int TIME_W   = 10;
    localparam int ENTRY_W  = 2 * TIME_W;
    localparam int ACTIVE_W = 7;
    localparam logic [ACTIVE_W-1:0] ACTIVE_MAX = '1;

    typedef enum logic [1:0] {
        OP_CHECK  = 2'd0,
        OP_INSERT = 2'd1,
        OP_COUNT  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_ORDER = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
        logic [TIME_W-1:0] probe_time;
    } req_t;

    typedef struct packed {
        logic                conflict;
        logic [ACTIVE_W-1:0] active_count;
        logic [1:0]          status;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_DECODE = 3'd1,
        S_SCAN   = 3'd2,
        S_DRAIN  = 3'd3,
        S_DONE   = 3'd4
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture the request
        logic decode;  // range, order and capacity checks, insert write, scan setup
        logic issue;   // read the next table slot
        logic finish;  // load the response register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_needed;
        logic last_addr;
        logic out_busy;
    } stat_t;

endpackage

// ===== design/interval_reservation_table_core.sv =====
// ----------------------------------------------------------------------------
// interval_reservation_table_core: interval reservation table
// stores half-open intervals and answers conflict checks, inserts and
// active-interval counts with one response per request
// ----------------------------------------------------------------------------
// sequence: insert, rejected requests and unused opcode go from request
//   capture through decode straight to the response register; check and
//   count first scan the interval ram, one ram read per stored entry
// throughput: one request at a time; a new request is taken only after the
//   scan over the interval ram is through and the response register is loaded
// reset: rst_n asynchronous, clears the entry count, the sequencer and the
//   response valid; the ram holds no reset and only filled slots are read
// ----------------------------------------------------------------------------
module interval_reservation_table_core
    import irt_pkg::*;
#(
    parameter int TIME_LIMIT  = 1023,
    parameter int MAX_ENTRIES = 64
) (
    input  logic clk,
    input  logic rst_n,
    // request channel, one transfer per command
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    // response channel, one transfer per command
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    // command and status groups between sequencer and datapath
    cmd_t  cmd;
    stat_t stat;

    // sequencer: idle -> decode -> (scan -> drain) -> done
    irt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: the response register lets a finished result wait for its
    // transfer while the sequencer already takes the next request
    irt_dp #(
        .TIME_LIMIT  (TIME_LIMIT),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ===== design/irt_ram.sv =====
// ----------------------------------------------------------------------------
// irt_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle, no reset on the array
// ----------------------------------------------------------------------------
module irt_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/irt_ctrl.sv =====
// ----------------------------------------------------------------------------
// irt_ctrl: request sequencer
// steps each request through capture, decode, table scan and response
// ----------------------------------------------------------------------------
module irt_ctrl
    import irt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   req_valid,
    output logic   req_ready,
    input  stat_t  stat,
    output cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = stat.scan_needed ? S_SCAN : S_DONE;
            end
            S_SCAN:
            begin
                if (stat.last_addr)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
            end
            S_SCAN:
            begin
                cmd.issue = 1'b1;
            end
            S_DRAIN:
            begin
                cmd = '0;
            end
            S_DONE:
            begin
                cmd.finish = !stat.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== design/irt_dp.sv =====
// ----------------------------------------------------------------------------
// irt_dp: table datapath
// request register, range checks, interval ram, scan accumulators and
// the response register
// ----------------------------------------------------------------------------
module irt_dp
    import irt_pkg::*;
#(
    parameter int TIME_LIMIT  = 1023,
    parameter int MAX_ENTRIES = 64
) (
    input  logic  clk,
    input  logic  rst_n,
    input  req_t  req,
    input  cmd_t  cmd,
    output stat_t stat,
    output logic  rsp_valid,
    input  logic  rsp_ready,
    output rsp_t  rsp
);

    localparam int IDXW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNTW   = $clog2(MAX_ENTRIES + 1);
    localparam int TCMP_W = 17;

    req_t                req_reg;
    status_t             status_reg;
    status_t             dec_status;
    logic [CNTW-1:0]     count_reg;
    logic [CNTW-1:0]     count_next;
    logic [IDXW-1:0]     addr_reg;
    logic [IDXW-1:0]     addr_next;
    logic                pend_reg;
    logic                hit_reg;
    logic                hit_next;
    logic                have_reg;
    logic                have_next;
    logic [TIME_W-1:0]   ps_reg;
    logic [TIME_W-1:0]   ps_next;
    logic [TIME_W-1:0]   pe_reg;
    logic [TIME_W-1:0]   pe_next;
    logic [ACTIVE_W-1:0] acc_reg;
    logic [ACTIVE_W-1:0] acc_next;
    rsp_t                rsp_reg;
    rsp_t                rsp_next;
    logic                rsp_valid_reg;
    logic                s_bad;
    logic                e_bad;
    logic                t_bad;
    logic                ram_we;
    logic [ENTRY_W-1:0]  rd_data;
    logic [TIME_W-1:0]   rd_s;
    logic [TIME_W-1:0]   rd_e;

    // range, order and capacity checks
    assign s_bad = TCMP_W'(req_reg.start_time) > TCMP_W'(TIME_LIMIT);
    assign e_bad = TCMP_W'(req_reg.end_time)   > TCMP_W'(TIME_LIMIT);
    assign t_bad = TCMP_W'(req_reg.probe_time) > TCMP_W'(TIME_LIMIT);

    always_comb
    begin
        dec_status = STAT_OK;
        case (req_reg.opcode)
            OP_CHECK:
            begin
                if (s_bad || e_bad)
                begin
                    dec_status = STAT_RANGE;
                end
            end
            OP_INSERT:
            begin
                if (s_bad || e_bad)
                begin
                    dec_status = STAT_RANGE;
                end
                else if (req_reg.end_time <= req_reg.start_time)
                begin
                    dec_status = STAT_ORDER;
                end
                else if (count_reg >= CNTW'(MAX_ENTRIES))
                begin
                    dec_status = STAT_FULL;
                end
            end
            OP_COUNT:
            begin
                if (t_bad)
                begin
                    dec_status = STAT_RANGE;
                end
            end
            default:
            begin
                dec_status = STAT_OK;
            end
        endcase
    end

    assign ram_we = cmd.decode && (req_reg.opcode == OP_INSERT) && (dec_status == STAT_OK);

    irt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDXW-1:0]),
        .wdata ({req_reg.start_time, req_reg.end_time}),
        .re    (cmd.issue),
        .raddr (addr_reg),
        .rdata (rd_data)
    );

    assign rd_s = rd_data[ENTRY_W-1:TIME_W];
    assign rd_e = rd_data[TIME_W-1:0];

    // status toward the controller
    assign stat.scan_needed = ((req_reg.opcode == OP_CHECK) || (req_reg.opcode == OP_COUNT))
                              && (dec_status == STAT_OK) && (count_reg != '0);
    assign stat.last_addr   = CNTW'(addr_reg) == (count_reg - CNTW'(1));
    assign stat.out_busy    = rsp_valid_reg && !rsp_ready;

    // scan accumulators
    always_comb
    begin
        count_next = count_reg;
        addr_next  = addr_reg;
        hit_next   = hit_reg;
        have_next  = have_reg;
        ps_next    = ps_reg;
        pe_next    = pe_reg;
        acc_next   = acc_reg;
        if (ram_we)
        begin
            count_next = count_reg + CNTW'(1);
        end
        if (cmd.decode)
        begin
            addr_next = '0;
            hit_next  = 1'b0;
            have_next = 1'b0;
            acc_next  = '0;
        end
        else
        begin
            if (cmd.issue)
            begin
                addr_next = addr_reg + IDXW'(1);
            end
            if (pend_reg)
            begin
                if (req_reg.opcode == OP_CHECK)
                begin
                    if (rd_s >= req_reg.start_time)
                    begin
                        if (rd_s < req_reg.end_time)
                        begin
                            hit_next = 1'b1;
                        end
                    end
                    else if (!have_reg || (rd_s > ps_reg)
                             || ((rd_s == ps_reg) && (rd_e > pe_reg)))
                    begin
                        have_next = 1'b1;
                        ps_next   = rd_s;
                        pe_next   = rd_e;
                    end
                end
                else if ((rd_s <= req_reg.probe_time) && (req_reg.probe_time < rd_e)
                         && (acc_reg != ACTIVE_MAX))
                begin
                    acc_next = acc_reg + ACTIVE_W'(1);
                end
            end
        end
    end

    // response
    always_comb
    begin
        rsp_next              = '0;
        rsp_next.status       = status_reg;
        if ((req_reg.opcode == OP_CHECK) && (status_reg == STAT_OK))
        begin
            rsp_next.conflict = hit_reg || (have_reg && (pe_reg > req_reg.start_time));
        end
        if ((req_reg.opcode == OP_COUNT) && (status_reg == STAT_OK))
        begin
            rsp_next.active_count = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            pend_reg  <= cmd.issue;
            if (cmd.finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.decode)
        begin
            status_reg <= dec_status;
        end
        if (cmd.finish)
        begin
            rsp_reg <= rsp_next;
        end
        addr_reg <= addr_next;
        hit_reg  <= hit_next;
        have_reg <= have_next;
        ps_reg   <= ps_next;
        pe_reg   <= pe_next;
        acc_reg  <= acc_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // the table only grows on a successful insert, one slot at a time
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> $past(ram_we) && (count_reg == $past(count_reg) + CNTW'(1)))
        else $error("entry count changed without an insert");

    // no write beyond the table
    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (count_reg < CNTW'(MAX_ENTRIES)))
        else $error("insert into a full table");

    // scan reads stay inside the filled slots
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (CNTW'(addr_reg) < count_reg))
        else $error("scan read past the last filled slot");

    // a waiting response is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(rsp_valid_reg && !rsp_ready))
        else $error("response register overwritten");

endmodule

// ===== bench/tb_interval_reservation_table_core.sv =====
// ----------------------------------------------------------------------------
// tb_interval_reservation_table_core: self-checking bench for the table core
// keeps its own copy of the interval table, predicts every response,
// and compares each response transfer field by field, in order
// ----------------------------------------------------------------------------
module tb_interval_reservation_table_core;
    import irt_pkg::*;

    localparam int TIME_MAX      = 1023;
    localparam int TABLE_DEPTH   = 64;
    localparam int IDLE_PCT      = 35;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int QUIET_ITEMS   = 150;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
    // slowest run: ~1100 requests, each at most a full table scan, plus stalls and gaps
    localparam int CYCLE_LIMIT   = 800000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    // shadow copy of the table, filled in acceptance order
    logic [TIME_W-1:0] shadow_start [TABLE_DEPTH];
    logic [TIME_W-1:0] shadow_end   [TABLE_DEPTH];
    int unsigned       shadow_count;

    // predicted responses, oldest first
    rsp_t        expected_rsp [$];
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned hold_left;
    bit          sender_jitter;
    bit          receiver_jitter;

    interval_reservation_table_core #(
        .TIME_LIMIT  (TIME_MAX),
        .MAX_ENTRIES (TABLE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit, counts every clock from the start
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_interval_reservation_table_core: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // successor hit or predecessor overlap, predecessor is the largest
    // (start, end) pair among entries starting before the query start
    function automatic logic overlap_found(logic [TIME_W-1:0] qs, logic [TIME_W-1:0] qe);
        logic              have_prev;
        logic [TIME_W-1:0] prev_s;
        logic [TIME_W-1:0] prev_e;
        have_prev = 1'b0;
        prev_s    = '0;
        prev_e    = '0;
        for (int k = 0; k < shadow_count; k++)
        begin
            if (shadow_start[k] >= qs)
            begin
                // any entry starting inside the query makes the successor hit
                if (shadow_start[k] < qe)
                    return 1'b1;
            end
            else if (!have_prev || shadow_start[k] > prev_s ||
                     (shadow_start[k] == prev_s && shadow_end[k] > prev_e))
            begin
                have_prev = 1'b1;
                prev_s    = shadow_start[k];
                prev_e    = shadow_end[k];
            end
        end
        return have_prev && (prev_e > qs);
    endfunction

    function automatic logic [ACTIVE_W-1:0] covering_count(logic [TIME_W-1:0] t);
        int unsigned n;
        n = 0;
        for (int k = 0; k < shadow_count; k++)
            if (shadow_start[k] <= t && t < shadow_end[k])
                n++;
        // saturating count
        return (n > ACTIVE_MAX) ? ACTIVE_MAX : ACTIVE_W'(n);
    endfunction

    // expected response for one accepted request, updates the shadow table
    function automatic rsp_t predict_table_response(req_t r);
        rsp_t p;
        p = '0;
        p.status = STAT_OK;
        case (opcode_t'(r.opcode))
            OP_CHECK:
            begin
                if (r.start_time > TIME_MAX || r.end_time > TIME_MAX)
                    p.status = STAT_RANGE;
                else
                    p.conflict = overlap_found(r.start_time, r.end_time);
            end
            OP_INSERT:
            begin
                // range first, then order, then capacity
                if (r.start_time > TIME_MAX || r.end_time > TIME_MAX)
                    p.status = STAT_RANGE;
                else if (r.end_time <= r.start_time)
                    p.status = STAT_ORDER;
                else if (shadow_count >= TABLE_DEPTH)
                    p.status = STAT_FULL;
                else
                begin
                    shadow_start[shadow_count] = r.start_time;
                    shadow_end[shadow_count]   = r.end_time;
                    shadow_count++;
                end
            end
            OP_COUNT:
            begin
                if (r.probe_time > TIME_MAX)
                    p.status = STAT_RANGE;
                else
                    p.active_count = covering_count(r.probe_time);
            end
            default:
                p = '0;  // unused opcode leaves everything alone
        endcase
        return p;
    endfunction

    // ------------------------------------------------------------------
    // response side: checks each transfer, then picks next ready
    // ------------------------------------------------------------------

    task automatic check_response(rsp_t got);
        rsp_t want;
        if (expected_rsp.size() == 0)
        begin
            $error("unexpected response: conflict %0d active_count %0d status %0d",
                   got.conflict, got.active_count, got.status);
            error_count++;
            return;
        end
        want = expected_rsp.pop_front();
        if (got.conflict !== want.conflict)
        begin
            $error("conflict: expected %0d, actual %0d", want.conflict, got.conflict);
            error_count++;
        end
        if (got.active_count !== want.active_count)
        begin
            $error("active_count: expected %0d, actual %0d",
                   want.active_count, got.active_count);
            error_count++;
        end
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
            check_response(rsp);
        // long hold-off is counted down here, hold_left dropping by one at each edge
        if (hold_left > 0)
        begin
            rsp_ready <= 1'b0;
            hold_left--;
        end
        else if (receiver_jitter)
            rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
        else
            rsp_ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // valid stays high across back-to-back transfers, lowered only for a gap or while draining
    task automatic send_item(req_t item);
        rsp_t predicted;
        if (sender_jitter && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
        // transfer happened at this edge
        predicted    = predict_table_response(item);
        expected_rsp = {expected_rsp, predicted};
    endtask

    task automatic send_op(opcode_t op, int lo, int hi, int t);
        req_t r;
        r.opcode     = op;
        r.start_time = TIME_W'(lo);
        r.end_time   = TIME_W'(hi);
        r.probe_time = TIME_W'(t);
        send_item(r);
    endtask

    // stop offering and wait until every response has come back
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    function automatic logic [TIME_W-1:0] clamp_time(int v);
        if (v < 0)
            return '0;
        if (v > TIME_MAX)
            return TIME_W'(TIME_MAX);
        return TIME_W'(v);
    endfunction

    // mostly well-formed commands aimed at stored entries, some noise
    function automatic req_t random_request();
        req_t r;
        int   pick;
        int   k;
        int   lo;
        int   span;
        r.opcode     = OP_NONE;
        r.start_time = TIME_W'($urandom_range(TIME_MAX));
        r.end_time   = TIME_W'($urandom_range(TIME_MAX));
        r.probe_time = TIME_W'($urandom_range(TIME_MAX));
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            // valid insert, mostly short intervals
            r.opcode = OP_INSERT;
            lo = $urandom_range(TIME_MAX - 1);
            if ($urandom_range(4) == 0)
                span = $urandom_range(TIME_MAX - lo, 1);
            else
                span = $urandom_range(48, 1);
            r.start_time = TIME_W'(lo);
            r.end_time   = clamp_time(lo + span);
        end
        else if (pick < 13)
        begin
            // insert with end not after start
            r.opcode = OP_INSERT;
            lo = $urandom_range(TIME_MAX);
            r.start_time = TIME_W'(lo);
            r.end_time   = TIME_W'($urandom_range(lo));
        end
        else if (pick < 55)
        begin
            r.opcode = OP_CHECK;
            if (shadow_count > 0 && $urandom_range(1) == 1)
            begin
                k  = $urandom_range(shadow_count - 1);
                lo = int'(clamp_time(int'(shadow_start[k]) + $urandom_range(16) - 8));
            end
            else
                lo = $urandom_range(TIME_MAX);
            r.start_time = TIME_W'(lo);
            if ($urandom_range(9) == 0)
                r.end_time = TIME_W'($urandom_range(lo));
            else
                r.end_time = clamp_time(lo + $urandom_range(64, 1));
        end
        else if (pick < 90)
        begin
            r.opcode = OP_COUNT;
            if (shadow_count > 0 && $urandom_range(2) != 0)
            begin
                // inside a stored interval or just on its end
                k = $urandom_range(shadow_count - 1);
                r.probe_time = clamp_time(int'(shadow_start[k]) +
                    $urandom_range(int'(shadow_end[k]) - int'(shadow_start[k])));
            end
        end
        else if (pick >= 94)
            r.opcode = 2'($urandom_range(3));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_empty_table();
        send_op(OP_CHECK, 0, TIME_MAX, 0);
        send_op(OP_CHECK, 600, 500, 0);      // empty query on empty table
        send_op(OP_COUNT, 0, 0, 0);
        send_op(OP_COUNT, 0, 0, TIME_MAX);
        send_op(OP_NONE, TIME_MAX, TIME_MAX, TIME_MAX);
    endtask

    task automatic test_insert_rules();
        send_op(OP_INSERT, 0, 1, 0);
        send_op(OP_INSERT, TIME_MAX - 1, TIME_MAX, 0);
        send_op(OP_INSERT, 100, 200, 0);
        send_op(OP_INSERT, 100, 200, 0);     // duplicate gets its own slot
        send_op(OP_INSERT, 300, 400, 0);
        send_op(OP_INSERT, 5, 5, 0);         // zero length
        send_op(OP_INSERT, 10, 3, 0);        // reversed
        send_op(OP_INSERT, TIME_MAX, TIME_MAX, 0);
    endtask

    task automatic test_conflict_cases();
        send_op(OP_CHECK, 0, 100, 0);        // successor at the query start
        send_op(OP_CHECK, 1, 100, 0);        // touching on both sides
        send_op(OP_CHECK, 200, 300, 0);
        send_op(OP_CHECK, 150, 160, 0);      // predecessor covers the query
        send_op(OP_CHECK, 250, 240, 0);      // empty query, no overlap
        send_op(OP_CHECK, 180, 170, 0);      // empty query, predecessor fires
        send_op(OP_CHECK, TIME_MAX, TIME_MAX, 0);
    endtask

    task automatic test_active_count();
        send_op(OP_COUNT, 0, 0, 0);
        send_op(OP_COUNT, 0, 0, 150);
        send_op(OP_COUNT, 0, 0, 200);
        send_op(OP_COUNT, 0, 0, TIME_MAX - 1);
    endtask

    // response side holds off while requests keep coming
    task automatic test_receiver_stall();
        wait_drained();
        sender_jitter   = 1'b0;
        receiver_jitter = 1'b0;
        hold_left       = HOLD_CYCLES;
        repeat (12)
            send_item(random_request());
    endtask

    task automatic test_random_traffic(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
        begin
            // one long stretch with both sides at full rate
            sender_jitter   = !(i >= n / 3 && i < n / 3 + QUIET_ITEMS);
            receiver_jitter = sender_jitter;
            send_item(random_request());
        end
    endtask

    // sender stops until every response is back, then resumes
    task automatic test_sender_pause();
        repeat (6)
            send_item(random_request());
        wait_drained();
        repeat (6)
            send_item(random_request());
    endtask

    task automatic test_full_table();
        int lo;
        if (shadow_count < TABLE_DEPTH)
            send_op(OP_INSERT, 0, TIME_MAX, 0);
        while (shadow_count < TABLE_DEPTH)
        begin
            lo = $urandom_range(TIME_MAX - 1);
            send_op(OP_INSERT, lo, int'(clamp_time(lo + $urandom_range(32, 1))), 0);
        end
        repeat (4)
        begin
            lo = $urandom_range(TIME_MAX - 1);
            send_op(OP_INSERT, lo, lo + 1, 0);
        end
        send_op(OP_CHECK, 0, TIME_MAX, 0);
        send_op(OP_COUNT, 0, 0, 0);
        send_op(OP_COUNT, 0, 0, TIME_MAX);
        repeat (10)
            send_item(random_request());
    endtask

    initial
    begin
        rst_n           = 1'b0;
        req_valid       = 1'b0;
        req             = '0;
        rsp_ready       = 1'b0;
        shadow_count    = 0;
        error_count     = 0;
        cycle_count     = 0;
        hold_left       = 0;
        sender_jitter   = 1'b0;
        receiver_jitter = 1'b0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at full rate, then the stall, random and full-table runs
        test_empty_table();
        test_insert_rules();
        test_conflict_cases();
        test_active_count();
        test_receiver_stall();
        test_random_traffic(RANDOM_ITEMS);
        test_sender_pause();
        test_full_table();

        wait_drained();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (error_count == 0 && expected_rsp.size() == 0)
            $display("tb_interval_reservation_table_core: done, clean");
        else
            $display("tb_interval_reservation_table_core: done, errors");
        $finish;
    end

endmodule
